// File: sv/lavm_pkg.sv
// ----------------------------------------------------------------------------
// Look-at view matrix package
// Widths, fixed-point formats and pipeline depths shared by the unit.
// ----------------------------------------------------------------------------
package lavm_pkg;

  localparam int CoordW        = 24;
  localparam int DirW          = CoordW + 1;
  localparam int CrossW        = 2 * DirW;
  localparam int NormW         = 25;
  localparam int SqW           = 2 * NormW;
  localparam int SumW          = SqW + 2;
  localparam int RootW         = SumW / 2;
  localparam int UnitFrac      = 14;
  localparam int QuotW         = UnitFrac + 1;
  localparam int UnitW         = 16;
  localparam int UnitMax       = 2 ** UnitFrac;
  localparam int CoordFracBits = 12;
  localparam int ProdFrac      = UnitFrac + CoordFracBits;
  localparam int RoundShift    = ProdFrac - CoordFracBits;
  localparam int ShiftW        = CoordW + 1;

  localparam int SqrtPerStage  = 2;
  localparam int SqrtStages    = RootW / SqrtPerStage;
  localparam int DivPerStage   = 3;
  localparam int DivStages     = QuotW / DivPerStage;
  localparam int UnitLat       = 5 + SqrtStages + 1 + DivStages + 1;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [UnitW-1:0]  unit_t;
  typedef logic signed [ShiftW-1:0] shift_t;

endpackage

// File: sv/lavm_if.sv
// ----------------------------------------------------------------------------
// Look-at view matrix channels
// Valid/ready interfaces for the camera word and the matrix word.
// ----------------------------------------------------------------------------
interface lavm_in_if;
  import lavm_pkg::*;

  logic   valid;
  logic   ready;
  coord_t camera_x;
  coord_t camera_y;
  coord_t camera_z;
  coord_t target_x;
  coord_t target_y;
  coord_t target_z;
  coord_t up_x;
  coord_t up_y;
  coord_t up_z;

  modport source (
    output valid, camera_x, camera_y, camera_z, target_x, target_y, target_z,
    output up_x, up_y, up_z,
    input  ready
  );
  modport sink (
    input  valid, camera_x, camera_y, camera_z, target_x, target_y, target_z,
    input  up_x, up_y, up_z,
    output ready
  );
endinterface

interface lavm_out_if;
  import lavm_pkg::*;

  logic   valid;
  logic   ready;
  unit_t  right_x;
  unit_t  right_y;
  unit_t  right_z;
  unit_t  trueup_x;
  unit_t  trueup_y;
  unit_t  trueup_z;
  unit_t  back_x;
  unit_t  back_y;
  unit_t  back_z;
  shift_t shift_x;
  shift_t shift_y;
  shift_t shift_z;

  modport source (
    output valid, right_x, right_y, right_z, trueup_x, trueup_y, trueup_z,
    output back_x, back_y, back_z, shift_x, shift_y, shift_z,
    input  ready
  );
  modport sink (
    input  valid, right_x, right_y, right_z, trueup_x, trueup_y, trueup_z,
    input  back_x, back_y, back_z, shift_x, shift_y, shift_z,
    output ready
  );
endinterface

// File: sv/lavm_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Restoring digit-by-digit root, two result bits per register stage.
// ----------------------------------------------------------------------------
module lavm_sqrt (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [lavm_pkg::SumW-1:0]    rad_i,
  output logic [lavm_pkg::RootW-1:0]   root_o
);
  import lavm_pkg::*;

  localparam int RemW = RootW + 3;

  logic [SumW-1:0]  rad_in  [SqrtStages];
  logic [RemW-1:0]  rem_in  [SqrtStages];
  logic [RootW-1:0] root_in [SqrtStages];
  logic [SumW-1:0]  rad_d   [SqrtStages];
  logic [RemW-1:0]  rem_d   [SqrtStages];
  logic [RootW-1:0] root_d  [SqrtStages];
  logic [SumW-1:0]  rad_q   [SqrtStages];
  logic [RemW-1:0]  rem_q   [SqrtStages];
  logic [RootW-1:0] root_q  [SqrtStages];

  always_comb begin
    rad_in[0]  = rad_i;
    rem_in[0]  = '0;
    root_in[0] = '0;
    for (int k = 1; k < SqrtStages; k++) begin
      rad_in[k]  = rad_q[k-1];
      rem_in[k]  = rem_q[k-1];
      root_in[k] = root_q[k-1];
    end
  end

  always_comb begin
    logic [SumW-1:0]  rad;
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    logic [RemW-1:0]  trial;
    for (int k = 0; k < SqrtStages; k++) begin
      rad  = rad_in[k];
      rem  = rem_in[k];
      root = root_in[k];
      for (int j = 0; j < SqrtPerStage; j++) begin
        rem   = {rem[RemW-3:0], rad[SumW-1 -: 2]};
        rad   = {rad[SumW-3:0], 2'b00};
        trial = {1'b0, root, 2'b01};
        if (rem >= trial) begin
          rem  = rem - trial;
          root = {root[RootW-2:0], 1'b1};
        end else begin
          root = {root[RootW-2:0], 1'b0};
        end
      end
      rad_d[k]  = rad;
      rem_d[k]  = rem;
      root_d[k] = root;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign root_o = root_q[SqrtStages-1];

endmodule

// File: sv/lavm_div.sv
// ----------------------------------------------------------------------------
// Pipelined rounding divider
// Forms (mag * 2^15 + len) / (2 * len) by restoring division, three
// quotient bits per register stage after one set-up stage.
// ----------------------------------------------------------------------------
module lavm_div (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [lavm_pkg::NormW-1:0]   mag_i,
  input  logic [lavm_pkg::RootW-1:0]   len_i,
  output logic [lavm_pkg::QuotW-1:0]   quot_o
);
  import lavm_pkg::*;

  localparam int NumW = NormW + QuotW + 1;
  localparam int DenW = RootW + 1;
  localparam int RemW = DenW + 1;

  logic [NumW-1:0]  num_q;
  logic [DenW-1:0]  den_q;

  logic [RemW-1:0]  rem_in [DivStages];
  logic [QuotW-1:0] low_in [DivStages];
  logic [QuotW-1:0] quo_in [DivStages];
  logic [DenW-1:0]  den_in [DivStages];
  logic [RemW-1:0]  rem_d  [DivStages];
  logic [QuotW-1:0] low_d  [DivStages];
  logic [QuotW-1:0] quo_d  [DivStages];
  logic [RemW-1:0]  rem_q  [DivStages];
  logic [QuotW-1:0] low_q  [DivStages];
  logic [QuotW-1:0] quo_q  [DivStages];
  logic [DenW-1:0]  den_s_q [DivStages];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= NumW'({mag_i, {QuotW{1'b0}}}) + NumW'(len_i);
      den_q <= {len_i, 1'b0};
    end
  end

  always_comb begin
    rem_in[0] = RemW'(num_q[NumW-1:QuotW]);
    low_in[0] = num_q[QuotW-1:0];
    quo_in[0] = '0;
    den_in[0] = den_q;
    for (int k = 1; k < DivStages; k++) begin
      rem_in[k] = rem_q[k-1];
      low_in[k] = low_q[k-1];
      quo_in[k] = quo_q[k-1];
      den_in[k] = den_s_q[k-1];
    end
  end

  always_comb begin
    logic [RemW-1:0]  rem;
    logic [QuotW-1:0] low;
    logic [QuotW-1:0] quo;
    for (int k = 0; k < DivStages; k++) begin
      rem = rem_in[k];
      low = low_in[k];
      quo = quo_in[k];
      for (int j = 0; j < DivPerStage; j++) begin
        rem = {rem[RemW-2:0], low[QuotW-1]};
        low = {low[QuotW-2:0], 1'b0};
        if (rem >= RemW'(den_in[k])) begin
          rem = rem - RemW'(den_in[k]);
          quo = {quo[QuotW-2:0], 1'b1};
        end else begin
          quo = {quo[QuotW-2:0], 1'b0};
        end
      end
      rem_d[k] = rem;
      low_d[k] = low;
      quo_d[k] = quo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q   <= rem_d;
      low_q   <= low_d;
      quo_q   <= quo_d;
      den_s_q <= den_in;
    end
  end

  assign quot_o = quo_q[DivStages-1];

endmodule

// File: sv/lavm_unit.sv
// ----------------------------------------------------------------------------
// Pipelined vector normalizer
// Scales a signed three-vector to a fixed magnitude window, takes the root of
// its squared length and divides each component by it with rounding.
// ----------------------------------------------------------------------------
module lavm_unit #(
  parameter int VecW = 50
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [VecW-1:0]            vec_i  [3],
  output lavm_pkg::unit_t                   unit_o [3]
);
  import lavm_pkg::*;

  localparam int PosW   = $clog2(VecW);
  localparam int NrmDly = 2 + SqrtStages;
  localparam int SgnDly = UnitLat - 2;

  logic [VecW-1:0]  mag_a_q [3];
  logic             sgn_a_q [3];
  logic [VecW-1:0]  mag_b_q [3];
  logic             lsh_b_q;
  logic [PosW-1:0]  amt_b_q;
  logic [NormW-1:0] nrm_c_q [3];
  logic [SqW-1:0]   sq_d_q  [3];
  logic [SumW-1:0]  sum_e_q;
  logic [RootW-1:0] len;
  logic [NormW-1:0] nrm_dly_q [NrmDly][3];
  logic             sgn_dly_q [SgnDly][3];
  logic [QuotW-1:0] quot    [3];
  logic [VecW-1:0]  orv;
  logic [PosW-1:0]  pos;

  always_comb begin
    orv = mag_a_q[0] | mag_a_q[1] | mag_a_q[2];
    pos = '0;
    for (int i = 0; i < VecW; i++) begin
      if (orv[i]) begin
        pos = PosW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sgn_a_q[i] <= vec_i[i][VecW-1];
        mag_a_q[i] <= vec_i[i][VecW-1] ? VecW'(-vec_i[i]) : VecW'(vec_i[i]);
      end
      mag_b_q <= mag_a_q;
      if (pos >= PosW'(NormW - 1)) begin
        lsh_b_q <= 1'b0;
        amt_b_q <= pos - PosW'(NormW - 1);
      end else begin
        lsh_b_q <= 1'b1;
        amt_b_q <= PosW'(NormW - 1) - pos;
      end
      for (int i = 0; i < 3; i++) begin
        nrm_c_q[i] <= lsh_b_q ? NormW'(mag_b_q[i] << amt_b_q)
                              : NormW'(mag_b_q[i] >> amt_b_q);
        sq_d_q[i]  <= SqW'(nrm_c_q[i]) * SqW'(nrm_c_q[i]);
      end
      sum_e_q <= SumW'(sq_d_q[0]) + SumW'(sq_d_q[1]) + SumW'(sq_d_q[2]);
      nrm_dly_q[0] <= nrm_c_q;
      for (int k = 1; k < NrmDly; k++) begin
        nrm_dly_q[k] <= nrm_dly_q[k-1];
      end
      sgn_dly_q[0] <= sgn_a_q;
      for (int k = 1; k < SgnDly; k++) begin
        sgn_dly_q[k] <= sgn_dly_q[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        if (quot[i] > QuotW'(UnitMax)) begin
          unit_o[i] <= sgn_dly_q[SgnDly-1][i] ? unit_t'(-UnitMax) : unit_t'(UnitMax);
        end else begin
          unit_o[i] <= sgn_dly_q[SgnDly-1][i] ? -unit_t'(quot[i]) : unit_t'(quot[i]);
        end
      end
    end
  end

  lavm_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .rad_i  (sum_e_q),
    .root_o (len)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    lavm_div u_div (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .mag_i  (nrm_dly_q[NrmDly-1][i]),
      .len_i  (len),
      .quot_o (quot[i])
    );
  end

endmodule

// File: sv/look_at_view_matrix_unit.sv
// ----------------------------------------------------------------------------
// Look-at view matrix unit
// Builds the 3x4 view matrix from a camera point, a target and an up vector.
// ----------------------------------------------------------------------------
// The unit takes one camera word every clock cycle while the output is not
// stalled; its latency is set mainly by the thirteen-stage square root and
// the six-stage rounding divider inside each normalizer. The whole
// pipeline advances whenever the output register is empty or being read, so
// a stall on the output holds every stage in place. When the look direction
// is zero or the up vector is parallel to it, every field of the matrix word
// is zero.
module look_at_view_matrix_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  lavm_in_if.sink    cam_i,
  lavm_out_if.source mat_o
);
  import lavm_pkg::*;

  localparam int Lat    = 3 + UnitLat + 4;
  localparam int CamDly = UnitLat + 4;
  localparam int DegDly = UnitLat + 3;
  localparam int PrW    = DirW + CoordW;
  localparam int XpW    = 2 * UnitW;
  localparam int XrW    = XpW + 2;
  localparam int DpW    = UnitW + CoordW;
  localparam int DsW    = DpW + 3;
  localparam int DrW    = DsW + 1;

  logic           adv;
  logic [Lat-1:0] vld_q;

  coord_t                   cam1_q [3];
  coord_t                   up1_q  [3];
  logic signed [DirW-1:0]   dir1_q [3];
  logic signed [DirW-1:0]   dir2_q [3];
  logic signed [DirW-1:0]   dir3_q [3];
  logic signed [PrW-1:0]    p2_q   [6];
  logic signed [CrossW-1:0] rc3_q  [3];
  logic                     deg3;
  logic                     deg_dly_q [DegDly];
  coord_t                   cam_dly_q [CamDly][3];
  unit_t                    look_u  [3];
  unit_t                    right_u [3];
  logic signed [XpW-1:0]    xp_q    [6];
  unit_t                    right29_q [3];
  unit_t                    look29_q  [3];
  unit_t                    right30_q [3];
  unit_t                    look30_q  [3];
  unit_t                    pu30_q    [3];
  unit_t                    right31_q [3];
  unit_t                    look31_q  [3];
  unit_t                    pu31_q    [3];
  logic signed [DpW-1:0]    dp_q      [9];
  unit_t                    right_q [3];
  unit_t                    trueup_q [3];
  unit_t                    back_q  [3];
  shift_t                   shift_q [3];

  function automatic unit_t sat_unit(input logic signed [XrW-1:0] v);
    logic signed [XrW-1:0] r;
    r = v >>> UnitFrac;
    if (r > XrW'(UnitMax)) begin
      return unit_t'(UnitMax);
    end else if (r < -XrW'(UnitMax)) begin
      return unit_t'(-UnitMax);
    end
    return unit_t'(r);
  endfunction

  function automatic shift_t sat_shift(input logic signed [DrW-1:0] v);
    logic signed [DrW-1:0] r;
    logic signed [DrW-1:0] hi;
    logic signed [DrW-1:0] lo;
    r  = (v + DrW'(2 ** (RoundShift - 1))) >>> RoundShift;
    hi = DrW'(2 ** (ShiftW - 1) - 1);
    lo = -DrW'(2 ** (ShiftW - 1));
    if (r > hi) begin
      return shift_t'(hi);
    end else if (r < lo) begin
      return shift_t'(lo);
    end
    return shift_t'(r);
  endfunction

  assign adv         = !vld_q[Lat-1] || mat_o.ready;
  assign cam_i.ready = adv;
  assign deg3        = (rc3_q[0] == '0) && (rc3_q[1] == '0) && (rc3_q[2] == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], cam_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cam1_q[0] <= cam_i.camera_x;
      cam1_q[1] <= cam_i.camera_y;
      cam1_q[2] <= cam_i.camera_z;
      up1_q[0]  <= cam_i.up_x;
      up1_q[1]  <= cam_i.up_y;
      up1_q[2]  <= cam_i.up_z;
      dir1_q[0] <= DirW'(cam_i.target_x) - DirW'(cam_i.camera_x);
      dir1_q[1] <= DirW'(cam_i.target_y) - DirW'(cam_i.camera_y);
      dir1_q[2] <= DirW'(cam_i.target_z) - DirW'(cam_i.camera_z);

      p2_q[0] <= PrW'(dir1_q[1]) * PrW'(up1_q[2]);
      p2_q[1] <= PrW'(dir1_q[2]) * PrW'(up1_q[1]);
      p2_q[2] <= PrW'(dir1_q[2]) * PrW'(up1_q[0]);
      p2_q[3] <= PrW'(dir1_q[0]) * PrW'(up1_q[2]);
      p2_q[4] <= PrW'(dir1_q[0]) * PrW'(up1_q[1]);
      p2_q[5] <= PrW'(dir1_q[1]) * PrW'(up1_q[0]);
      dir2_q  <= dir1_q;

      for (int i = 0; i < 3; i++) begin
        rc3_q[i] <= CrossW'(p2_q[2*i]) - CrossW'(p2_q[2*i+1]);
      end
      dir3_q <= dir2_q;

      deg_dly_q[0] <= deg3;
      for (int k = 1; k < DegDly; k++) begin
        deg_dly_q[k] <= deg_dly_q[k-1];
      end
      cam_dly_q[0] <= cam1_q;
      for (int k = 1; k < CamDly; k++) begin
        cam_dly_q[k] <= cam_dly_q[k-1];
      end

      xp_q[0]   <= XpW'(right_u[1]) * XpW'(look_u[2]);
      xp_q[1]   <= XpW'(right_u[2]) * XpW'(look_u[1]);
      xp_q[2]   <= XpW'(right_u[2]) * XpW'(look_u[0]);
      xp_q[3]   <= XpW'(right_u[0]) * XpW'(look_u[2]);
      xp_q[4]   <= XpW'(right_u[0]) * XpW'(look_u[1]);
      xp_q[5]   <= XpW'(right_u[1]) * XpW'(look_u[0]);
      right29_q <= right_u;
      look29_q  <= look_u;

      for (int i = 0; i < 3; i++) begin
        pu30_q[i] <= sat_unit(XrW'(xp_q[2*i]) - XrW'(xp_q[2*i+1])
                              + XrW'(2 ** (UnitFrac - 1)));
      end
      right30_q <= right29_q;
      look30_q  <= look29_q;

      for (int i = 0; i < 3; i++) begin
        dp_q[i]   <= DpW'(right30_q[i]) * DpW'(cam_dly_q[CamDly-1][i]);
        dp_q[3+i] <= DpW'(pu30_q[i]) * DpW'(cam_dly_q[CamDly-1][i]);
        dp_q[6+i] <= DpW'(look30_q[i]) * DpW'(cam_dly_q[CamDly-1][i]);
      end
      right31_q <= right30_q;
      pu31_q    <= pu30_q;
      look31_q  <= look30_q;

      if (deg_dly_q[DegDly-1]) begin
        for (int i = 0; i < 3; i++) begin
          right_q[i]  <= '0;
          trueup_q[i] <= '0;
          back_q[i]   <= '0;
          shift_q[i]  <= '0;
        end
      end else begin
        right_q  <= right31_q;
        trueup_q <= pu31_q;
        for (int i = 0; i < 3; i++) begin
          back_q[i] <= -look31_q[i];
        end
        shift_q[0] <= sat_shift(-(DrW'(dp_q[0]) + DrW'(dp_q[1]) + DrW'(dp_q[2])));
        shift_q[1] <= sat_shift(-(DrW'(dp_q[3]) + DrW'(dp_q[4]) + DrW'(dp_q[5])));
        shift_q[2] <= sat_shift(DrW'(dp_q[6]) + DrW'(dp_q[7]) + DrW'(dp_q[8]));
      end
    end
  end

  lavm_unit #(
    .VecW (DirW)
  ) u_look (
    .clk_i  (clk_i),
    .en_i   (adv),
    .vec_i  (dir3_q),
    .unit_o (look_u)
  );

  lavm_unit #(
    .VecW (CrossW)
  ) u_right (
    .clk_i  (clk_i),
    .en_i   (adv),
    .vec_i  (rc3_q),
    .unit_o (right_u)
  );

  assign mat_o.valid    = vld_q[Lat-1];
  assign mat_o.right_x  = right_q[0];
  assign mat_o.right_y  = right_q[1];
  assign mat_o.right_z  = right_q[2];
  assign mat_o.trueup_x = trueup_q[0];
  assign mat_o.trueup_y = trueup_q[1];
  assign mat_o.trueup_z = trueup_q[2];
  assign mat_o.back_x   = back_q[0];
  assign mat_o.back_y   = back_q[1];
  assign mat_o.back_z   = back_q[2];
  assign mat_o.shift_x  = shift_q[0];
  assign mat_o.shift_y  = shift_q[1];
  assign mat_o.shift_z  = shift_q[2];

endmodule
